@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the shift-and-add logarithm block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, skipped while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger, skipped while rst_n is low.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fpl_pkg.sv @@
// Package with the types, constants and logarithm table of the shift-and-add logarithm block.
`timescale 1ns / 1ps
`default_nettype none

package fpl_pkg;

    // Fraction width of argument and result.
    localparam int FRAC_BITS   = 64;
    localparam int HALF_BITS   = FRAC_BITS / 2;
    localparam int TABLE_DEPTH = 49;
    localparam int STEP_W      = 6;
    localparam int CNT_W       = $clog2(FRAC_BITS);
    localparam int WIDE_BITS   = 192;

    // Limits and reset value of the reduction step count.
    localparam logic [STEP_W-1:0] MIN_STEPS   = STEP_W'(16);
    localparam logic [STEP_W-1:0] MAX_STEPS   = STEP_W'(FRAC_BITS - 16);
    localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(16);

    // Configuration port layout.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_STEPS = 1'b0;

    // Reciprocal of three: floor(w / 3) = (w * DIV3_MAGIC) >> (FRAC_BITS + 1).
    localparam logic [FRAC_BITS-1:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PREP,
        ST_DIVIDE,
        ST_MUL_TT,
        ST_MUL_TZ,
        ST_MUL_W3,
        ST_FINISH
    } state_t;

    // Status of the iterative multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    typedef logic [TABLE_DEPTH-1:0][FRAC_BITS-1:0] log_table_t;

    // floor(2^(WIDE_BITS - sh) / k) by long division, evaluated at elaboration.
    function automatic logic [WIDE_BITS-1:0] series_term(int unsigned sh, int unsigned k);
        logic [WIDE_BITS-1:0] q;
        logic [8:0]           rem;
        int                   b;
        int                   top;
        q   = '0;
        rem = '0;
        top = int'(WIDE_BITS) - int'(sh);
        for (b = top; b >= 0; b--) begin
            rem = {rem[7:0], (b == top)};
            if (rem >= 9'(k)) begin
                rem  = rem - 9'(k);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(log(1 + 2^-i) * 2^64) from the alternating series in 192-bit working.
    function automatic logic [FRAC_BITS-1:0] log_entry(int unsigned i);
        logic [WIDE_BITS-1:0] pos_sum;
        logic [WIDE_BITS-1:0] neg_sum;
        logic [WIDE_BITS-1:0] diff;
        int unsigned          k;
        pos_sum = '0;
        neg_sum = '0;
        for (k = 1; i * k < WIDE_BITS; k++) begin
            if (k[0]) begin
                pos_sum = pos_sum + series_term(i * k, k);
            end else begin
                neg_sum = neg_sum + series_term(i * k, k);
            end
        end
        diff = pos_sum - neg_sum;
        return diff[WIDE_BITS-1:WIDE_BITS-FRAC_BITS];
    endfunction

    function automatic log_table_t build_log_table();
        log_table_t  tab;
        int unsigned i;
        tab[0] = '0;
        for (i = 1; i < TABLE_DEPTH; i++) begin
            tab[i] = log_entry(i);
        end
        return tab;
    endfunction

    // Constant table of log(1 + 2^-i), entry 0 unused.
    localparam log_table_t LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

@@ sv/fpl_mul64.sv @@
// Iterative 64x64 multiplier built on one shared 32x32 multiplier, returning the high half.
`timescale 1ns / 1ps
`default_nettype none

module fpl_mul64 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fpl_pkg::FRAC_BITS-1:0] a,
    input  wire logic [fpl_pkg::FRAC_BITS-1:0] b,
    output logic      [fpl_pkg::FRAC_BITS-1:0] hi,
    output fpl_pkg::mul_status_t               status
);

    localparam int FB = fpl_pkg::FRAC_BITS;
    localparam int HB = fpl_pkg::HALF_BITS;

    logic [FB-1:0]   a_reg, a_next;
    logic [FB-1:0]   b_reg, b_next;
    logic            busy_reg, busy_next;
    logic [1:0]      idx_reg, idx_next;
    logic [FB-1:0]   prod_reg, prod_next;
    logic            prod_vld_reg, prod_vld_next;
    logic [1:0]      prod_idx_reg, prod_idx_next;
    logic [2*FB-1:0] acc_reg, acc_next;
    logic            done_reg, done_next;

    logic [HB-1:0]   a_half;
    logic [HB-1:0]   b_half;
    logic [2*FB-1:0] addend;

    // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1.
    assign a_half = idx_reg[1] ? a_reg[FB-1:HB] : a_reg[HB-1:0];
    assign b_half = idx_reg[0] ? b_reg[FB-1:HB] : b_reg[HB-1:0];

    // Align the registered partial product to its weight.
    always_comb
    begin
        case (prod_idx_reg) inside
            2'd0:       addend = {{FB{1'b0}}, prod_reg};
            2'd1, 2'd2: addend = {{HB{1'b0}}, prod_reg, {HB{1'b0}}};
            default:    addend = {prod_reg, {FB{1'b0}}};
        endcase
    end

    // Issue and accumulate sequencing.
    always_comb
    begin
        a_next        = a_reg;
        b_next        = b_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        prod_next     = prod_reg;
        prod_vld_next = 1'b0;
        prod_idx_next = prod_idx_reg;
        acc_next      = acc_reg;
        done_next     = 1'b0;

        if (start && !busy_reg) begin
            a_next    = a;
            b_next    = b;
            busy_next = 1'b1;
            idx_next  = 2'd0;
            acc_next  = '0;
        end else begin
            if (busy_reg) begin
                prod_next     = FB'(a_half) * FB'(b_half);
                prod_vld_next = 1'b1;
                prod_idx_next = idx_reg;
                idx_next      = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    busy_next = 1'b0;
                end
            end
            if (prod_vld_reg) begin
                acc_next = acc_reg + addend;
                if (prod_idx_reg == 2'd3) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg     <= 1'b0;
            idx_reg      <= 2'd0;
            prod_vld_reg <= 1'b0;
            prod_idx_reg <= 2'd0;
            done_reg     <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            prod_vld_reg <= prod_vld_next;
            prod_idx_reg <= prod_idx_next;
            done_reg     <= done_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign hi          = acc_reg[2*FB-1:FB];
    assign status.busy = busy_reg | prod_vld_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ sv/fixed_point_log1p_shift_add.sv @@
// Top level of the shift-and-add logarithm: sequencer, reduction, divider and APB register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Returns log(1 + frac_in/2^64) as a 64-bit unsigned fraction, one transaction at a time.
// A transaction runs r + 1 shift-add reduction steps, where r is reduction_steps clamped to
// 16..48, then one setup step, the restoring divider at one quotient bit per cycle, three
// 64x64 multiplies on the shared 32x32 multiplier, and a final step that forms the sum. When
// the reduction leaves no residual, the divider and multiplies are skipped. in_stall is high
// while a transaction is in work; the result waits in an output register, so the next
// transaction can start while it is still stalled. reduction_steps sits at APB address 0
// and resets to 16.
module fixed_point_log1p_shift_add (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [fpl_pkg::FRAC_BITS-1:0]     frac_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [fpl_pkg::FRAC_BITS-1:0]     log_value,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fpl_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [fpl_pkg::PDATA_W-1:0]       pwdata,
    output logic      [fpl_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int FB = fpl_pkg::FRAC_BITS;
    localparam int SW = fpl_pkg::STEP_W;
    localparam int CW = fpl_pkg::CNT_W;
    localparam logic [CW-1:0] DIV_LAST = CW'(FB - 1);
    localparam logic [FB+1:0] S_BASE   = {2'b10, {FB{1'b0}}};

    fpl_pkg::state_t state_reg, state_next;

    logic [SW-1:0] steps_reg;
    logic [FB-1:0] x_reg, x_next;
    logic [FB-1:0] p_reg, p_next;
    logic [FB-1:0] d_reg, d_next;
    logic [FB-1:0] acc_reg, acc_next;
    logic [FB-1:0] t_reg, t_next;
    logic [SW-1:0] r_reg, r_next;
    logic [SW-1:0] i_reg, i_next;
    logic [FB+1:0] s_reg, s_next;
    logic [FB+2:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          first_reg;
    logic          out_valid_reg, out_valid_next;
    logic [FB-1:0] log_value_reg, log_value_next;

    logic                 in_accept;
    logic                 cfg_write;
    logic [SW-1:0]        steps_clamped;
    logic [SW-1:0]        ii;
    logic [FB:0]          shifted;
    logic [FB-1:0]        v;
    logic                 take;
    logic                 last_step;
    logic [FB-1:0]        d_after;
    logic [FB+2:0]        rem_sh;
    logic [FB+2:0]        s_ext;
    logic                 ge;
    logic                 out_free;
    logic                 mul_start;
    logic [FB-1:0]        mul_a;
    logic [FB-1:0]        mul_b;
    logic [FB-1:0]        mul_hi;
    fpl_pkg::mul_status_t mul_stat;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[fpl_pkg::PADDR_W-1:2] == fpl_pkg::REG_STEPS);
    assign prdata    = (paddr[fpl_pkg::PADDR_W-1:2] == fpl_pkg::REG_STEPS)
                       ? {{(fpl_pkg::PDATA_W - SW){1'b0}}, steps_reg} : '0;

    assign steps_clamped = (steps_reg < fpl_pkg::MIN_STEPS) ? fpl_pkg::MIN_STEPS :
                           (steps_reg > fpl_pkg::MAX_STEPS) ? fpl_pkg::MAX_STEPS : steps_reg;

    // Handshake.
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign log_value = log_value_reg;

    // Reduction step: v = (1:p) >> ii, taken when it fits in the deficit.
    assign ii        = (i_reg < r_reg) ? i_reg : r_reg;
    assign shifted   = {1'b1, p_reg} >> ii;
    assign v         = shifted[FB-1:0];
    assign take      = (v <= d_reg);
    assign last_step = (i_reg == r_reg + SW'(1));
    assign d_after   = take ? (d_reg - v) : d_reg;

    // Restoring divider step.
    assign rem_sh = {rem_reg[FB+1:0], 1'b0};
    assign s_ext  = {1'b0, s_reg};
    assign ge     = (rem_sh >= s_ext);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpl_pkg::ST_IDLE:
            begin
                if (in_accept) begin
                    state_next = fpl_pkg::ST_REDUCE;
                end
            end
            fpl_pkg::ST_REDUCE:
            begin
                if (last_step) begin
                    state_next = (d_after == '0) ? fpl_pkg::ST_FINISH : fpl_pkg::ST_PREP;
                end
            end
            fpl_pkg::ST_PREP:
            begin
                state_next = fpl_pkg::ST_DIVIDE;
            end
            fpl_pkg::ST_DIVIDE:
            begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = fpl_pkg::ST_MUL_TT;
                end
            end
            fpl_pkg::ST_MUL_TT:
            begin
                if (mul_stat.done) begin
                    state_next = fpl_pkg::ST_MUL_TZ;
                end
            end
            fpl_pkg::ST_MUL_TZ:
            begin
                if (mul_stat.done) begin
                    state_next = fpl_pkg::ST_MUL_W3;
                end
            end
            fpl_pkg::ST_MUL_W3:
            begin
                if (mul_stat.done) begin
                    state_next = fpl_pkg::ST_FINISH;
                end
            end
            fpl_pkg::ST_FINISH:
            begin
                if (out_free) begin
                    state_next = fpl_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Handshake and multiplier controls.
    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        mul_a     = t_reg;
        mul_b     = t_reg;
        unique case (state_reg)
            fpl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            fpl_pkg::ST_MUL_TT:
            begin
                mul_start = first_reg;
            end
            fpl_pkg::ST_MUL_TZ:
            begin
                mul_start = first_reg;
                mul_b     = mul_hi;
            end
            fpl_pkg::ST_MUL_W3:
            begin
                mul_start = first_reg;
                mul_a     = mul_hi;
                mul_b     = fpl_pkg::DIV3_MAGIC;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        x_next         = x_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        log_value_next = log_value_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            fpl_pkg::ST_IDLE:
            begin
                if (in_accept) begin
                    x_next   = frac_in;
                    d_next   = frac_in;
                    p_next   = '0;
                    acc_next = '0;
                    t_next   = '0;
                    i_next   = SW'(1);
                    r_next   = steps_clamped;
                end
            end
            fpl_pkg::ST_REDUCE:
            begin
                if (take) begin
                    d_next   = d_reg - v;
                    p_next   = p_reg + v;
                    acc_next = acc_reg + fpl_pkg::LOG_TABLE[ii];
                end
                i_next = i_reg + SW'(1);
            end
            fpl_pkg::ST_PREP:
            begin
                // Divisor 2^65 + x + p, dividend starts as the deficit.
                s_next   = S_BASE + {2'b00, x_reg} + {2'b00, p_reg};
                rem_next = {3'b000, d_reg};
                cnt_next = '0;
            end
            fpl_pkg::ST_DIVIDE:
            begin
                rem_next = ge ? (rem_sh - s_ext) : rem_sh;
                t_next   = {t_reg[FB-2:0], ge};
                cnt_next = cnt_reg + CW'(1);
            end
            fpl_pkg::ST_MUL_W3:
            begin
                // High half of w times the magic constant, halved, is w / 3.
                if (mul_stat.done) begin
                    t_next = t_reg + {1'b0, mul_hi[FB-1:1]};
                end
            end
            fpl_pkg::ST_FINISH:
            begin
                if (out_free) begin
                    log_value_next = acc_reg + {t_reg[FB-2:0], 1'b0};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= fpl_pkg::ST_IDLE;
            steps_reg     <= fpl_pkg::STEPS_RESET;
            r_reg         <= fpl_pkg::STEPS_RESET;
            i_reg         <= SW'(1);
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            first_reg     <= (state_next != state_reg);
            out_valid_reg <= out_valid_next;
            if (cfg_write) begin
                steps_reg <= pwdata[SW-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        p_reg         <= p_next;
        d_reg         <= d_next;
        acc_reg       <= acc_next;
        t_reg         <= t_next;
        s_reg         <= s_next;
        rem_reg       <= rem_next;
        log_value_reg <= log_value_next;
    end

    // Shared multiplier for t*t, t*z and the division by three.
    fpl_mul64 u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .hi     (mul_hi),
        .status (mul_stat)
    );

    // Checks on the sequencer and datapath.
    `ASSERT_NEXT(a_accept_reduce, in_accept, state_reg == fpl_pkg::ST_REDUCE,
                 "accepted transaction did not enter reduction")
    `ASSERT_CLK(a_mul_start_idle, !mul_start || !mul_stat.busy,
                "multiplier started while busy")
    `ASSERT_CLK(a_rem_below_div, (state_reg != fpl_pkg::ST_DIVIDE) || (rem_reg < s_ext),
                "divider remainder not below divisor")
    `ASSERT_CLK(a_step_bound, (state_reg != fpl_pkg::ST_REDUCE) || (i_reg <= r_reg + SW'(1)),
                "reduction step index beyond its bound")

endmodule

`default_nettype wire

@@ bench/fixed_point_log1p_shift_add_tb.sv @@
// Testbench for the shift-and-add logarithm block: directed, sweep and random checks.
`timescale 1ns / 1ps

// Drives fractions into the block under random pacing and back-pressure, predicts
// each logarithm from the fraction and the current step count, and compares every
// result in order. The step count register is written between phases over its
// whole range, including clamped and masked values and a write to a spare address.
module fixed_point_log1p_shift_add_tb;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASE_ITEMS   = 125;
    localparam int MAX_REPORTS   = 50;
    localparam int TAIL_CYCLES   = 160;
    localparam logic [fpl_pkg::PADDR_W-1:0] STEPS_ADDR =
        fpl_pkg::PADDR_W'(4 * fpl_pkg::REG_STEPS);
    localparam int SPARE_INDEX   = 1;
    localparam logic [fpl_pkg::PADDR_W-1:0] SPARE_ADDR = fpl_pkg::PADDR_W'(4 * SPARE_INDEX);

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [fpl_pkg::FRAC_BITS-1:0]   frac_in;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [fpl_pkg::FRAC_BITS-1:0]   log_value;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [fpl_pkg::PADDR_W-1:0]     paddr;
    logic [fpl_pkg::PDATA_W-1:0]     pwdata;
    logic [fpl_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    // Local copy of the block's state: step count register and log(1+2^-i) constants.
    logic [fpl_pkg::STEP_W-1:0]      steps_reg;
    logic [63:0]                     log_consts [1:48];

    logic [fpl_pkg::FRAC_BITS-1:0]   pending_logs [$];
    int                              error_count;
    int                              results_checked;
    int                              transactions_sent;
    int                              settings_used;

    // Sender pacing state.
    int                              burst_left;
    int                              gap_style;

    // Receiver back-pressure state.
    int                              stall_mode;
    int                              mode_left = 0;
    int                              run_left = 0;
    logic                            stall_hold = 1'b0;

    fixed_point_log1p_shift_add uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .frac_in   (frac_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .log_value (log_value),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // floor(log(1 + 2^-i) * 2^64) from the alternating series, each term floored at 192 bits.
    function automatic logic [63:0] series_log(int i);
        logic [191:0] plus_sum;
        logic [191:0] minus_sum;
        logic [191:0] diff;
        int           k;
        plus_sum  = '0;
        minus_sum = '0;
        for (k = 1; i * k < 192; k++)
        begin
            if (k % 2 == 1)
                plus_sum = plus_sum + ((192'd1 << (192 - i * k)) / 192'(k));
            else
                minus_sum = minus_sum + ((192'd1 << (192 - i * k)) / 192'(k));
        end
        diff = plus_sum - minus_sum;
        return diff[191:128];
    endfunction

    // Step count as the block uses it, held to its legal range.
    function automatic int clamped_steps(logic [fpl_pkg::STEP_W-1:0] raw);
        int r;
        r = int'(raw);
        if (r < int'(fpl_pkg::MIN_STEPS))
            r = int'(fpl_pkg::MIN_STEPS);
        if (r > int'(fpl_pkg::MAX_STEPS))
            r = int'(fpl_pkg::MAX_STEPS);
        return r;
    endfunction

    // Expected log(1 + x/2^64): factor reduction, then the atanh series on the residual.
    function automatic logic [63:0] predict_log1p(logic [63:0] x);
        logic [63:0]  prod;
        logic [63:0]  deficit;
        logic [63:0]  acc;
        logic [63:0]  step_v;
        logic [63:0]  quot;
        logic [63:0]  sq;
        logic [63:0]  cube;
        logic [65:0]  divisor;
        logic [127:0] wide;
        int           r;
        int           i;
        int           k;
        r       = clamped_steps(steps_reg);
        prod    = '0;
        deficit = x;
        acc     = '0;
        for (i = 1; i <= r + 1; i++)
        begin
            k      = (i < r) ? i : r;
            step_v = (prod >> k) | (64'd1 << (64 - k));
            if (step_v <= deficit)
            begin
                deficit = deficit - step_v;
                prod    = prod + step_v;
                acc     = acc + log_consts[k];
            end
        end
        // Exact reduction: the accumulator is already the answer.
        if (deficit == 0)
            return acc;
        divisor = {2'b10, 64'd0} + {2'b00, x} + {2'b00, prod};
        wide    = {deficit, 64'd0} / {62'd0, divisor};
        quot    = wide[63:0];
        wide    = {64'd0, quot} * {64'd0, quot};
        sq      = wide[127:64];
        wide    = {64'd0, quot} * {64'd0, sq};
        cube    = wide[127:64];
        return acc + ((quot + cube / 64'd3) << 1);
    endfunction

    // A fraction that is a product of chosen factors, so the reduction tends to end exact.
    function automatic logic [63:0] exact_product();
        logic [63:0] prod;
        int          r;
        int          i;
        int          k;
        r    = clamped_steps(steps_reg);
        prod = '0;
        for (i = 1; i <= r + 1; i++)
        begin
            k = (i < r) ? i : r;
            if ($urandom_range(0, 1) == 1)
                prod = prod + ((prod >> k) | (64'd1 << (64 - k)));
        end
        return prod;
    endfunction

    // Random fraction drawn from several shapes.
    function automatic logic [63:0] random_frac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return raw;
            4:          return raw >> $urandom_range(1, 63);
            5:          return ~(raw >> $urandom_range(1, 63));
            6:          return (64'd1 << $urandom_range(0, 63))
                               + 64'($urandom_range(0, 2)) - 64'd1;
            7, 8:       return exact_product();
            default:    return exact_product() + 64'($urandom_range(1, 3)) - 64'd2;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("[%0t] %s: got %h, want %h", $time, what, got, want);
        error_count++;
    endtask

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_logs.size() == 0)
            begin
                report_mismatch("result with nothing pending", log_value, '0);
            end
            else
            begin
                logic [63:0] want;
                want = pending_logs.pop_front();
                results_checked++;
                if (log_value !== want)
                    report_mismatch("log_value", log_value, want);
            end
        end
    end

    // Back-pressure on results: free running, scattered stalls, or long held stretches.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(200, 3000);
        end
        mode_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    stall_hold = !stall_hold;
                    run_left   = stall_hold ? $urandom_range(1, 250) : $urandom_range(1, 40);
                end
                run_left--;
                out_stall <= stall_hold;
            end
        endcase
    end

    // One transaction on the input side; valid stays high after acceptance.
    task automatic send_frac(logic [63:0] x);
        @(negedge clk);
        in_valid <= 1'b1;
        frac_in  <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_logs.push_back(predict_log1p(x));
        transactions_sent++;
    endtask

    // Gap after a transaction, following the current burst pattern.
    task automatic sender_pause();
        int gap;
        gap = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 10);
            case (gap_style)
                0:       gap = 0;
                1:       gap = $urandom_range(1, 8);
                default: gap = $urandom_range(1, 150);
            endcase
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            frac_in  <= {$urandom, $urandom};
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Stop sending and wait for every pending result.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_logs.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [fpl_pkg::PADDR_W-1:0] addr,
                              logic [fpl_pkg::PDATA_W-1:0] data,
                              output logic [fpl_pkg::PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr && (addr >> 2) == fpl_pkg::REG_STEPS)
            steps_reg = data[fpl_pkg::STEP_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the step count, then read it back.
    task automatic set_steps(logic [fpl_pkg::PDATA_W-1:0] value);
        logic [fpl_pkg::PDATA_W-1:0] rd;
        apb_access(1'b1, STEPS_ADDR, value, rd);
        apb_access(1'b0, STEPS_ADDR, '0, rd);
        if (rd !== fpl_pkg::PDATA_W'(steps_reg))
            report_mismatch("steps readback", 64'(rd), 64'(steps_reg));
        settings_used++;
    endtask

    // Extremes of the fraction and an exact product at the reset step count.
    task automatic test_fraction_extremes();
        logic [63:0] values [$];
        values = '{64'd0, 64'd1, 64'd2, '1, 64'h8000_0000_0000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
                   64'h0000_0000_0000_8000, 64'h0001_0000_0000_0000,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'hC000_0000_0000_0000};
        foreach (values[n])
            send_frac(values[n]);
        send_frac(exact_product());
        drain();
    endtask

    // Step counts below, at and above the legal range, plus masked upper bits.
    task automatic test_steps_sweep();
        logic [fpl_pkg::PDATA_W-1:0] settings [$];
        settings = '{32'd0, 32'd15, 32'd17, 32'd47, 32'd48, 32'd49, 32'd63, 32'hFFFF_FFE5};
        foreach (settings[n])
        begin
            set_steps(settings[n]);
            send_frac({$urandom, $urandom});
            if (n == 0 || n == 4 || n == 6)
                send_frac(exact_product());
            drain();
        end
    endtask

    // A write to an unused address must leave the step count alone.
    task automatic test_spare_register();
        logic [fpl_pkg::PDATA_W-1:0] rd;
        set_steps(32'd20);
        apb_access(1'b1, SPARE_ADDR, 32'h0000_0030, rd);
        apb_access(1'b0, STEPS_ADDR, '0, rd);
        if (rd !== fpl_pkg::PDATA_W'(steps_reg))
            report_mismatch("steps after spare write", 64'(rd), 64'(steps_reg));
        send_frac({$urandom, $urandom});
        drain();
    endtask

    // Random fractions in phases, each with its own step count and pacing.
    task automatic test_random_stream();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                drain();
                case ($urandom_range(0, 3))
                    0:       set_steps(32'(fpl_pkg::MIN_STEPS));
                    1:       set_steps(32'(fpl_pkg::MAX_STEPS));
                    default: set_steps($urandom);
                endcase
                gap_style  = $urandom_range(0, 2);
                burst_left = 0;
            end
            send_frac(random_frac());
            sender_pause();
        end
        drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        frac_in           = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        error_count       = 0;
        results_checked   = 0;
        transactions_sent = 0;
        settings_used     = 0;
        burst_left        = 0;
        gap_style         = 0;
        steps_reg         = fpl_pkg::STEPS_RESET;
        for (int i = 1; i <= 48; i++)
            log_consts[i] = series_log(i);
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fraction_extremes();
        test_steps_sweep();
        test_spare_register();
        test_random_stream();

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending_logs.size() != 0)
            report_mismatch("results still pending", 64'(pending_logs.size()), '0);
        $display("Sent %0d transactions and checked %0d results under %0d step settings.",
                 transactions_sent, results_checked, settings_used);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #30_000_000;
        $display("Timed out with %0d results pending.", pending_logs.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fpl_pkg.sv
sv/fpl_mul64.sv
sv/fixed_point_log1p_shift_add.sv
bench/fixed_point_log1p_shift_add_tb.sv
